// ----- rtl/gkl_pkg.sv -----
`default_nettype none
package gkl_pkg;
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_PLACE = 2'd2;
   localparam logic [1:0] CMD_RSVD  = 2'd3;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
   localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
   localparam logic [1:0] REG_LINE_HEIGHT  = 2'd2;
   localparam logic [1:0] REG_TAB_SPACING  = 2'd3;
   localparam int HULL_W = 19;
   typedef logic [HULL_W-1:0] hull_type;
endpackage
`default_nettype wire

// ----- rtl/glyph_kerning_layout_unit.sv -----
// Row-hull kerning layout. Load items (command 0) write one glyph row's hull; start items
// (command 1) reset the pen; place items (command 2) handle newline, tab or a glyph. A glyph
// placement reads two hull rows per row step over a single-port memory, the first in ST_RDA
// and the second in ST_RDB, then subtracts and compares in ST_CMP. A tab divides the pen by
// tab_spacing with a restoring divider, one quotient bit a cycle. Loads, starts, newlines and
// glyphs that were never loaded finish in ST_DONE. One item is in flight at a time and
// req_stall is high while busy; a finished glyph holds in its last step while the previous
// result still waits in the output register. The hull and ink memories have no reset and
// need no clearing pass if the user places a glyph only once all its rows are loaded, which
// the block does not enforce; per-glyph presence bits reset in flip-flops.
`default_nettype none
module glyph_kerning_layout_unit #(
   parameter int GLYPH_CODES = 256,
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLS    = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [3:0]  req_row_index,
   input  wire logic [15:0] req_letter_row,
   input  wire logic [15:0] req_margin_row,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_placed_code,
   output logic signed [15:0] rsp_origin_x,
   output logic [15:0]      rsp_origin_y,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import gkl_pkg::*;

   localparam int CW = (GLYPH_CODES > 1) ? $clog2(GLYPH_CODES) : 1;
   localparam int EC = (MAX_COLS < 16) ? MAX_COLS : 16;
   localparam int ER = (MAX_ROWS < 16) ? MAX_ROWS : 16;
   localparam int RW = (ER > 1) ? $clog2(ER) : 1;
   localparam int AW = CW + RW;
   localparam int DEPTH = 1 << AW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDA  = 3'd1;
   localparam logic [2:0] ST_RDB  = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [4:0] gw_ff, gh_ff;
   logic [7:0] lh_ff, ts_ff;
   logic [2:0] st_ff, st_in;
   logic [1:0] req_cmd_ff;
   logic [7:0] code_ff;
   logic [3:0] row_ff;
   logic [15:0] lm_ff, mm_ff;
   logic signed [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic prev_valid_ff, prev_valid_in;
   logic [7:0] prev_code_ff, prev_code_in;
   logic [GLYPH_CODES-1:0] present_ff;
   logic [15:0] ink_ff [GLYPH_CODES];
   logic [15:0] ink_a_ff, ink_b_ff;
   logic a_ink, b_ink;
   logic [4:0] y_ff, y_in;
   logic [4:0] h_ff;
   hull_type a_ff, a_in;
   logic found_ff, found_in;
   logic signed [6:0] best_ff, best_in;
   logic [15:0] quo_ff, quo_in, rem_ff, rem_in, dnd_ff, dnd_in;
   logic [4:0] cnt_ff, cnt_in;
   logic rsp_load;
   logic rv_ff;
   logic [7:0] rc_ff;
   logic signed [15:0] rx_ff;
   logic [15:0] ry_ff;

   hull_type mem [DEPTH];
   hull_type rd_ff;
   logic [AW-1:0] rd_addr;
   logic rd_en, wr_en;
   hull_type wr_data;

   wire accept = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE);

   // effective sizes
   logic [4:0] weff, heff;
   always_comb begin
      weff = (gw_ff > 5'(EC)) ? 5'(EC) : gw_ff;
      heff = (gh_ff > 5'(ER)) ? 5'(ER) : gh_ff;
   end

   // row spans for load
   logic [15:0] cm, lmk, mmk;
   logic [3:0] llo, mlo;
   logic [4:0] lhi, mhi;
   logic lany, many;
   always_comb begin
      cm = 16'((17'd1 << weff) - 17'd1);
      lmk = lm_ff & cm;
      mmk = mm_ff & cm;
      llo = '0; lhi = '0; mlo = '0; mhi = 5'd1;
      lany = 1'b0; many = 1'b0;
      for (int i = 15; i >= 0; i--) begin
         if (lmk[i]) llo = 4'(i);
         if (mmk[i]) mlo = 4'(i);
      end
      for (int i = 0; i < 16; i++) begin
         if (lmk[i]) begin lhi = 5'(i + 1); lany = 1'b1; end
         if (mmk[i]) begin mhi = 5'(i + 1); many = 1'b1; end
      end
      if (!lany) begin llo = '0; lhi = '0; end
      if (!many) begin mlo = '0; mhi = 5'd1; end
      wr_data = {lany, mhi, mlo, lhi, llo};
   end

   wire code_ok = 32'(code_ff) < GLYPH_CODES;
   wire row_ok = 32'(row_ff) < MAX_ROWS;
   logic [CW-1:0] ci, pci;
   assign ci = code_ok ? code_ff[CW-1:0] : '0;
   assign pci = prev_code_ff[CW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[rd_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // ink words of the previous and the new glyph, read once per placement
   always_ff @(posedge clock) begin
      if (wr_en) ink_ff[ci][row_ff] <= lany;
      if (st_ff == ST_DONE && req_cmd_ff == CMD_PLACE) begin
         ink_a_ff <= ink_ff[pci];
         ink_b_ff <= ink_ff[ci];
      end
   end

   // hull fields of the row read
   function automatic logic [3:0] f_ll(hull_type e, logic ink);
      f_ll = ink ? e[3:0] : e[12:9];
   endfunction
   function automatic logic [4:0] f_lr(hull_type e, logic ink);
      f_lr = ink ? e[8:4] : e[17:13];
   endfunction
   function automatic logic f_lv(hull_type e, logic ink);
      f_lv = ink ? e[18] : 1'b1;
   endfunction

   logic [15:0] hmask;
   assign hmask = 16'((17'd1 << heff) - 17'd1);
   assign a_ink = (ink_a_ff & hmask) != 16'd0;
   assign b_ink = (ink_b_ff & hmask) != 16'd0;

   logic signed [6:0] d1, d2, c1;
   logic [16:0] trial;
   logic signed [17:0] sum_x;
   logic [16:0] nx, sy;

   always_comb begin
      st_in = st_ff; y_in = y_ff; a_in = a_ff; found_in = found_ff; best_in = best_ff;
      quo_in = quo_ff; rem_in = rem_ff; dnd_in = dnd_ff; cnt_in = cnt_ff;
      pen_x_in = pen_x_ff; pen_y_in = pen_y_ff;
      prev_valid_in = prev_valid_ff; prev_code_in = prev_code_ff;
      rd_en = 1'b0; wr_en = 1'b0; rsp_load = 1'b0;
      rd_addr = {ci, y_ff[RW-1:0]};
      d1 = '0; d2 = '0; c1 = '0; trial = '0; sum_x = '0; nx = '0; sy = '0;
      case (st_ff)
         ST_IDLE: ;
         ST_DONE: begin
            st_in = ST_IDLE;
            case (req_cmd_ff)
               CMD_LOAD: begin
                  rd_addr = {ci, row_ff[RW-1:0]};
                  wr_en = code_ok && row_ok;
               end
               CMD_START: begin
                  pen_x_in = '0; pen_y_in = '0; prev_valid_in = 1'b0;
               end
               CMD_PLACE: begin
                  if (code_ff == CH_NEWLINE) begin
                     pen_x_in = '0;
                     sy = 17'(pen_y_ff) + 17'(lh_ff);
                     pen_y_in = sy[16] ? 16'hFFFF : sy[15:0];
                     prev_valid_in = 1'b0;
                  end else if (code_ff == CH_TAB) begin
                     prev_valid_in = 1'b0;
                     if (ts_ff != 8'd0) begin
                        st_in = ST_DIV;
                        dnd_in = pen_x_ff[15] ? 16'd0 : pen_x_ff;
                        rem_in = '0; quo_in = '0; cnt_in = 5'd16;
                     end
                  end else if (code_ok && present_ff[ci]) begin
                     st_in = (heff == 5'd0) ? ST_CMP : ST_RDA;
                     y_in = '0; found_in = 1'b0; best_in = '0;
                  end
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (cnt_ff != 5'd0) begin
               trial = {rem_ff, dnd_ff[15]};
               dnd_in = {dnd_ff[14:0], 1'b0};
               if (trial >= 17'(ts_ff)) begin
                  rem_in = 16'(trial - 17'(ts_ff));
                  quo_in = {quo_ff[14:0], 1'b1};
               end else begin
                  rem_in = trial[15:0];
                  quo_in = {quo_ff[14:0], 1'b0};
               end
               cnt_in = cnt_ff - 5'd1;
            end else begin
               // (q+1)*ts with q < 2^15, ts < 256, result fits 24 bits
               nx = (({1'b0, quo_ff} + 17'd1) > 17'd32767) ? 17'd32767 :
                    17'((({8'd0, quo_ff} + 24'd1) * 24'(ts_ff)) > 24'd32767 ?
                    24'd32767 : (({8'd0, quo_ff} + 24'd1) * 24'(ts_ff)));
               pen_x_in = 16'(nx);
               st_in = ST_IDLE;
            end
         end
         ST_RDA: begin
            rd_en = 1'b1;
            rd_addr = {prev_valid_ff ? pci : ci, y_ff[RW-1:0]};
            st_in = ST_RDB;
         end
         ST_RDB: begin
            rd_en = 1'b1;
            rd_addr = {ci, y_ff[RW-1:0]};
            a_in = rd_ff;
            st_in = ST_CMP;
         end
         ST_CMP: begin
            if (y_ff == h_ff) begin
               // hold the glyph until the previous result is taken
               if (!rv_ff || !rsp_stall) begin
                  sum_x = 18'(pen_x_ff) + 18'(found_ff ? best_ff : 7'sd0);
                  pen_x_in = (sum_x > 18'sd32767) ? 16'sh7FFF :
                             (sum_x < -18'sd32768) ? 16'sh8000 : 16'(sum_x);
                  prev_valid_in = 1'b1; prev_code_in = code_ff;
                  rsp_load = 1'b1;
                  st_in = ST_IDLE;
               end
            end else begin
               if (!prev_valid_ff) begin
                  // first glyph: ll in a_ff (read of own code)
                  c1 = -$signed({3'd0, f_ll(a_ff, b_ink)});
                  if (f_lv(a_ff, b_ink) && (!found_ff || c1 > best_ff)) begin
                     best_in = c1; found_in = 1'b1;
                  end
               end else begin
                  d1 = $signed({2'd0, f_lr(a_ff, a_ink)}) - $signed({3'd0, rd_ff[12:9]});
                  d2 = $signed({2'd0, a_ff[17:13]}) - $signed({3'd0, f_ll(rd_ff, b_ink)});
                  if (f_lv(a_ff, a_ink) && (!found_ff || d1 > best_ff)) begin
                     best_in = d1; found_in = 1'b1;
                     if (f_lv(rd_ff, b_ink) && d2 > d1) best_in = d2;
                  end else if (f_lv(rd_ff, b_ink) && (!found_ff || d2 > best_ff)) begin
                     best_in = d2; found_in = 1'b1;
                  end
               end
               y_in = y_ff + 5'd1;
               st_in = (y_ff + 5'd1 == h_ff) ? ST_CMP : ST_RDA;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_cmd_ff <= req_command; code_ff <= req_char_code; row_ff <= req_row_index;
         lm_ff <= req_letter_row; mm_ff <= req_margin_row;
      end
      if (st_ff == ST_DONE && req_cmd_ff == CMD_PLACE) h_ff <= heff;
      y_ff <= y_in; a_ff <= a_in; best_ff <= best_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dnd_ff <= dnd_in; cnt_ff <= cnt_in;
      if (rsp_load) begin
         rc_ff <= code_ff; rx_ff <= pen_x_in; ry_ff <= pen_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; pen_x_ff <= '0; pen_y_ff <= '0;
         prev_valid_ff <= 1'b0; prev_code_ff <= '0; found_ff <= 1'b0;
         present_ff <= '0; rv_ff <= 1'b0;
         gw_ff <= 5'd8; gh_ff <= 5'd8; lh_ff <= 8'd10; ts_ff <= 8'd32;
      end else begin
         st_ff <= accept ? ST_DONE : st_in;
         pen_x_ff <= pen_x_in; pen_y_ff <= pen_y_in;
         prev_valid_ff <= prev_valid_in; prev_code_ff <= prev_code_in;
         found_ff <= found_in;
         if (wr_en) present_ff[ci] <= 1'b1;
         if (rsp_load) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               REG_GLYPH_WIDTH:  gw_ff <= csr_data[4:0];
               REG_GLYPH_HEIGHT: gh_ff <= csr_data[4:0];
               REG_LINE_HEIGHT:  lh_ff <= csr_data;
               REG_TAB_SPACING:  ts_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_placed_code = rc_ff;
   assign rsp_origin_x = rx_ff;
   assign rsp_origin_y = ry_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> req_stall) else $error("accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> rv_ff) else $error("result dropped");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |-> (cnt_ff <= 5'd16)) else $error("divider count");
endmodule
`default_nettype wire

// ----- tb/sv/glyph_kerning_layout_unit_test.sv -----
`timescale 1ns / 1ps
module glyph_kerning_layout_unit_test;
   import gkl_pkg::*;

   typedef struct {
      logic [7:0]  code;
      logic [15:0] x;
      logic [15:0] y;
   } glyph_pos_type;

   class layout_scoreboard;
      logic [18:0] hull[4096];
      bit          present[256];
      bit [15:0]   ink[256];
      int          pen_x, pen_y, prev_code;
      bit          prev_on;
      int          gw = 8, gh = 8, lh = 10, ts = 32;
      glyph_pos_type pos_q[$];
      int          errors, placed;

      function void set_reg(logic [1:0] idx, int val);
         case (idx)
            REG_GLYPH_WIDTH: gw = val & 31;
            REG_GLYPH_HEIGHT: gh = val & 31;
            REG_LINE_HEIGHT: lh = val & 255;
            default: ts = val & 255;
         endcase
      endfunction

      function void span(input bit [15:0] m, output int lo, output int hi, output bit found);
         found = 0;
         lo = 0;
         hi = 0;
         for (int i = 0; i < 16; i++) begin
            if (m[i]) begin
               if (!found) lo = i;
               hi = i + 1;
               found = 1;
            end
         end
      endfunction

      function bit inkless(int c, int h);
         bit [16:0] hm;
         hm = (17'd1 << h) - 17'd1;
         return (ink[c] & hm[15:0]) == 0;
      endfunction

      function void get_row(int c, int y, bit nl, output bit lv, output int ll,
                            output int lr, output int ml, output int mr);
         logic [18:0] e;
         e = hull[c*16 + y];
         ml = e[12:9];
         mr = e[17:13];
         if (nl) begin
            lv = 1;
            ll = ml;
            lr = mr;
         end else begin
            lv = e[18];
            ll = e[3:0];
            lr = e[8:4];
         end
      endfunction

      function int kern_shift(int c);
         int h, best, all, alr, aml, amr, bll, blr, bml, bmr;
         bit found, alv, blv, an, bn;
         h = gh > 16 ? 16 : gh;
         bn = inkless(c, h);
         an = inkless(prev_code, h);
         found = 0;
         best = 0;
         for (int y = 0; y < h; y++) begin
            get_row(c, y, bn, blv, bll, blr, bml, bmr);
            if (!prev_on) begin
               if (blv && (!found || bll < best)) begin
                  best = bll;
                  found = 1;
               end
            end else begin
               get_row(prev_code, y, an, alv, all, alr, aml, amr);
               if (alv && (!found || alr - bml > best)) begin
                  best = alr - bml;
                  found = 1;
               end
               if (blv && (!found || amr - bll > best)) begin
                  best = amr - bll;
                  found = 1;
               end
            end
         end
         if (!found) return 0;
         return prev_on ? best : -best;
      endfunction

      function void note(logic [1:0] cmd, logic [7:0] code, logic [3:0] row,
                         logic [15:0] lm, logic [15:0] mm);
         int w, llo, lhi, mlo, mhi, nx;
         bit [16:0] cm;
         bit lf, mf;
         glyph_pos_type p;
         if (cmd == CMD_LOAD) begin
            w = gw > 16 ? 16 : gw;
            cm = (17'd1 << w) - 17'd1;
            span(lm & cm[15:0], llo, lhi, lf);
            span(mm & cm[15:0], mlo, mhi, mf);
            if (!mf) begin
               mlo = 0;
               mhi = 1;
            end
            hull[code*16 + row] = {lf, 5'(mhi), 4'(mlo), 5'(lhi), 4'(llo)};
            present[code] = 1;
            ink[code][row] = lf;
         end else if (cmd == CMD_START) begin
            pen_x = 0;
            pen_y = 0;
            prev_on = 0;
         end else if (cmd == CMD_PLACE) begin
            if (code == CH_NEWLINE) begin
               pen_x = 0;
               pen_y = pen_y + lh > 65535 ? 65535 : pen_y + lh;
               prev_on = 0;
            end else if (code == CH_TAB) begin
               if (ts != 0) begin
                  nx = ts * ((pen_x < 0 ? 0 : pen_x) / ts + 1);
                  pen_x = nx > 32767 ? 32767 : nx;
               end
               prev_on = 0;
            end else if (present[code]) begin
               pen_x = pen_x + kern_shift(code);
               if (pen_x > 32767) pen_x = 32767;
               if (pen_x < -32768) pen_x = -32768;
               prev_on = 1;
               prev_code = code;
               p.code = code;
               p.x = pen_x[15:0];
               p.y = pen_y[15:0];
               pos_q.push_back(p);
            end
         end
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         $display("mismatch %s: got %0h want %0h", what, got, want);
         errors++;
      endtask

      task check(logic [7:0] code, logic [15:0] x, logic [15:0] y);
         glyph_pos_type p;
         if (pos_q.size() == 0) begin
            report("unexpected glyph", {8'd0, code}, 16'd0);
         end else begin
            p = pos_q.pop_front();
            placed++;
            if (code !== p.code) report("placed_code", {8'd0, code}, {8'd0, p.code});
            if (x !== p.x) report("origin_x", x, p.x);
            if (y !== p.y) report("origin_y", y, p.y);
         end
      endtask
   endclass

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, rsp_stall = 0, csr_write = 0;
   logic [1:0]  req_command = 0, csr_index = 0;
   logic [7:0]  req_char_code = 0, csr_data = 0;
   logic [3:0]  req_row_index = 0;
   logic [15:0] req_letter_row = 0, req_margin_row = 0;
   logic        req_stall, rsp_valid;
   logic [7:0]  rsp_placed_code;
   logic signed [15:0] rsp_origin_x;
   logic [15:0] rsp_origin_y;

   glyph_kerning_layout_unit u_top (.*);

   layout_scoreboard sb = new();
   bit [15:0] rows_done[256];
   int        glyph_codes[$];
   int        sent, stall_left, cycles;
   bit        calm;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check(rsp_placed_code, rsp_origin_x, rsp_origin_y);
         stall_left = calm ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send(logic [1:0] cmd, logic [7:0] code, logic [3:0] row,
                       logic [15:0] lm, logic [15:0] mm);
      int gap;
      gap = calm ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_char_code <= code;
      req_row_index <= row;
      req_letter_row <= lm;
      req_margin_row <= mm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(cmd, code, row, lm, mm);
      sent++;
      if (cmd == CMD_LOAD) begin
         rows_done[code][row] = 1;
         if (rows_done[code] == 16'hFFFF && !(code inside {glyph_codes}) && code < 128)
            glyph_codes.push_back(code);
      end
   endtask

   function automatic logic [15:0] row_mask();
      int a, b;
      a = $urandom_range(0, 15);
      b = $urandom_range(a, 15);
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'd1 << a;
         3: return (16'hFFFF >> (15 - b)) & (16'hFFFF << a);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic load_glyph(int code, bit no_ink);
      for (int r = 0; r < 16; r++)
         send(CMD_LOAD, 8'(code), 4'(r), no_ink ? 16'h0 : row_mask(), row_mask());
   endtask

   task automatic place(int code);
      send(CMD_PLACE, 8'(code), 4'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // loads and tabs give no result, so a settle gap follows the last glyph
   task automatic set_regs(int w, int h, int l, int t);
      req_valid <= 0;
      while (sb.pos_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_write <= 1;
      csr_index <= REG_GLYPH_WIDTH;
      csr_data <= 8'(w);
      @(posedge clock);
      csr_index <= REG_GLYPH_HEIGHT;
      csr_data <= 8'(h);
      @(posedge clock);
      csr_index <= REG_LINE_HEIGHT;
      csr_data <= 8'(l);
      @(posedge clock);
      csr_index <= REG_TAB_SPACING;
      csr_data <= 8'(t);
      @(posedge clock);
      csr_write <= 0;
      sb.set_reg(REG_GLYPH_WIDTH, w);
      sb.set_reg(REG_GLYPH_HEIGHT, h);
      sb.set_reg(REG_LINE_HEIGHT, l);
      sb.set_reg(REG_TAB_SPACING, t);
   endtask

   task automatic random_items(int n);
      int stop, r, c;
      stop = sent + n;
      while (sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 6 || glyph_codes.size() == 0) begin
            c = $urandom_range(0, 127);
            if (c == CH_TAB || c == CH_NEWLINE) c += 2;
            load_glyph(c, $urandom_range(0, 7) == 0);
         end else if (r < 10) begin
            send(CMD_LOAD, 8'($urandom_range(128, 191)), 4'($urandom), row_mask(),
                 row_mask());
         end else if (r < 12) begin
            send(CMD_RSVD, 8'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
         end else if (r < 14) begin
            send(CMD_START, 8'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
         end else if (r < 16) begin
            place($urandom_range(192, 255));
         end else if (r < 24) begin
            place(CH_NEWLINE);
         end else if (r < 30) begin
            place(CH_TAB);
         end else begin
            place(glyph_codes[$urandom_range(0, glyph_codes.size() - 1)]);
         end
         if ($urandom_range(0, 60) == 0) calm = !calm;
      end
      calm = 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: plain, inkless and margin-free glyphs at reset settings
      load_glyph(65, 0);
      load_glyph(66, 1);
      for (int r = 0; r < 16; r++) send(CMD_LOAD, 8'd67, 4'(r), 16'hFFFF, 16'h0);
      place(66);
      place(65);
      place(66);
      place(67);
      place(65);
      send(CMD_RSVD, 8'hFF, 4'hF, 16'hFFFF, 16'hFFFF);
      place(CH_NEWLINE);
      place(CH_TAB);
      place(67);
      place(200);
      place(65);
      send(CMD_START, 8'd0, 4'd0, 16'd0, 16'd0);
      place(67);
      place(255);

      random_items(250);
      set_regs(16, 16, 255, 255);
      random_items(250);
      set_regs(1, 1, 0, 1);
      random_items(200);
      set_regs(5, 12, 7, 3);
      random_items(200);
      set_regs(16, 3, 1, 200);
      random_items(200);
      set_regs(9, 0, 33, 0);
      random_items(120);
      set_regs($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 255),
               $urandom_range(1, 255));
      random_items(200);

      // pen saturation on both axes
      set_regs(16, 16, 255, 255);
      send(CMD_START, 8'd0, 4'd0, 16'd0, 16'd0);
      calm = 1;
      repeat (260) place(CH_NEWLINE);
      repeat (130) place(CH_TAB);
      repeat (4) place(67);
      place(CH_TAB);
      place(65);
      calm = 0;
      random_items(120);

      req_valid <= 0;
      while (sb.pos_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d items over eight register settings, %0d glyph positions checked",
               sent, sb.placed);
      if (sb.errors == 0 && sb.pos_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/gkl_pkg.sv
rtl/glyph_kerning_layout_unit.sv
tb/sv/glyph_kerning_layout_unit_test.sv
